>>> hw/rtl/hcipr_pkg.sv
// Package for the H4 packet reassembler: payload structs, codes and constants.
// No dependencies; every other RTL file of the block imports it.
package hcipr_pkg;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int LEN_W       = 17;

    localparam logic [7:0] IND_EVENT = 8'h04;
    localparam logic [7:0] IND_ACL   = 8'h02;
    localparam logic [7:0] IND_SCO   = 8'h03;

    localparam logic [1:0] TYPE_EVENT = 2'd0;
    localparam logic [1:0] TYPE_ACL   = 2'd1;
    localparam logic [1:0] TYPE_SCO   = 2'd2;

    localparam logic [1:0] KIND_BYTE     = 2'd0;
    localparam logic [1:0] KIND_UNKNOWN  = 2'd1;
    localparam logic [1:0] KIND_TOO_LONG = 2'd2;

    localparam logic [1:0] REG_EVENT_MAX = 2'd0;
    localparam logic [1:0] REG_ACL_MAX   = 2'd1;
    localparam logic [1:0] REG_SCO_MAX   = 2'd2;

    localparam logic [8:0]       EVENT_MAX_RST = 9'd258;
    localparam logic [LEN_W-1:0] ACL_MAX_RST   = 17'd65540;
    localparam logic [8:0]       SCO_MAX_RST   = 9'd259;

    typedef enum logic [1:0] {
        PH_INDICATOR,
        PH_HEADER,
        PH_PAYLOAD,
        PH_DISCARD
    } t_phase;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       chunk_last;
    } t_in_word;

    typedef struct packed {
        logic [1:0] result_kind;
        logic [1:0] pkt_type;
        logic [7:0] out_byte;
        logic       packet_last;
    } t_out_word;

    typedef struct packed {
        logic [8:0]       event_max;
        logic [LEN_W-1:0] acl_max;
        logic [8:0]       sco_max;
    } t_cfg;

    // One queue entry: up to four result words from a single input word.
    typedef struct packed {
        logic [1:0]       cnt_m1;
        logic [1:0]       kind;
        logic [1:0]       ptype;
        logic [3:0][7:0]  bytes;
        logic             last;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

>>> hw/rtl/hcipr_front.sv
// Front end: accepts input words, tracks packet phase and header bytes,
// and pushes result commands. Depends on hcipr_pkg.
module hcipr_front import hcipr_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    input  t_in_word  i_data,
    input  t_cfg      i_cfg,
    input  t_q_status i_qstat,
    output logic      o_push,
    output t_cmd      o_cmd
);

    t_phase           r_phase, n_phase;
    logic [1:0]       r_type, n_type;
    logic [LEN_W-1:0] r_taken, n_taken;
    logic [LEN_W-1:0] r_expected, n_expected;
    logic [3:0][7:0]  r_hs;

    logic             w_acc;
    logic [7:0]       w_b;
    logic             w_ind_ok;
    logic [1:0]       w_ind_type;
    logic [1:0]       w_hidx;
    logic [1:0]       w_final_idx;
    logic             w_hdr_done;
    logic [LEN_W-1:0] w_len;
    logic [LEN_W-1:0] w_hl;
    logic [LEN_W-1:0] w_max;
    logic             w_too_long;
    logic             w_no_payload;
    logic [LEN_W-1:0] w_taken_inc;
    logic             w_pay_last;
    logic [3:0][7:0]  w_hdr_bytes;

    assign w_acc       = i_valid && !i_qstat.full;
    assign w_b         = i_data.data_byte;
    assign w_hidx      = r_taken[1:0] - 2'd1;
    assign w_taken_inc = r_taken + 17'd1;
    assign w_pay_last  = w_taken_inc >= r_expected;

    always_comb begin
        w_ind_ok   = 1'b1;
        w_ind_type = TYPE_EVENT;
        unique case (w_b)
            IND_EVENT: w_ind_type = TYPE_EVENT;
            IND_ACL:   w_ind_type = TYPE_ACL;
            IND_SCO:   w_ind_type = TYPE_SCO;
            default:   w_ind_ok   = 1'b0;
        endcase
    end

    always_comb begin
        unique case (r_type)
            TYPE_EVENT: begin
                w_final_idx = 2'd1;
                w_hl        = 17'd3;
                w_len       = {9'd0, w_b} + 17'd3;
                w_max       = {8'd0, i_cfg.event_max};
            end
            TYPE_ACL: begin
                w_final_idx = 2'd3;
                w_hl        = 17'd5;
                w_len       = {1'b0, w_b, r_hs[2]} + 17'd5;
                w_max       = i_cfg.acl_max;
            end
            default: begin
                w_final_idx = 2'd2;
                w_hl        = 17'd4;
                w_len       = {9'd0, w_b} + 17'd4;
                w_max       = {8'd0, i_cfg.sco_max};
            end
        endcase
    end

    assign w_hdr_done   = w_hidx == w_final_idx;
    assign w_too_long   = w_len > w_max;
    assign w_no_payload = w_len == w_hl;

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            w_hdr_bytes[k] = (w_hidx == 2'(k)) ? w_b : r_hs[k];
        end
    end

    // next phase
    always_comb begin
        n_phase = r_phase;
        unique case (r_phase)
            PH_INDICATOR: begin
                if (w_acc) begin
                    if (w_ind_ok) n_phase = PH_HEADER;
                    else n_phase = i_data.chunk_last ? PH_INDICATOR : PH_DISCARD;
                end
            end
            PH_HEADER: begin
                if (w_acc && w_hdr_done) begin
                    if (w_too_long) n_phase = i_data.chunk_last ? PH_INDICATOR : PH_DISCARD;
                    else if (w_no_payload) n_phase = PH_INDICATOR;
                    else n_phase = PH_PAYLOAD;
                end
            end
            PH_PAYLOAD: begin
                if (w_acc && w_pay_last) n_phase = PH_INDICATOR;
            end
            PH_DISCARD: begin
                if (w_acc && i_data.chunk_last) n_phase = PH_INDICATOR;
            end
            default: n_phase = PH_INDICATOR;
        endcase
    end

    // datapath and queue push
    always_comb begin
        n_type       = r_type;
        n_taken      = r_taken;
        n_expected   = r_expected;
        o_push       = 1'b0;
        o_cmd.cnt_m1 = 2'd0;
        o_cmd.kind   = KIND_BYTE;
        o_cmd.ptype  = r_type;
        o_cmd.bytes  = '0;
        o_cmd.last   = 1'b0;
        unique case (r_phase)
            PH_INDICATOR: begin
                n_taken    = 17'd1;
                n_expected = '0;
                if (w_acc) begin
                    if (w_ind_ok) begin
                        n_type = w_ind_type;
                    end else begin
                        o_push      = 1'b1;
                        o_cmd.kind  = KIND_UNKNOWN;
                        o_cmd.ptype = TYPE_EVENT;
                    end
                end
            end
            PH_HEADER: begin
                if (w_acc) begin
                    n_taken = w_taken_inc;
                    if (w_hdr_done) begin
                        o_push = 1'b1;
                        if (w_too_long) begin
                            o_cmd.kind = KIND_TOO_LONG;
                            n_taken    = 17'd1;
                        end else begin
                            o_cmd.cnt_m1 = w_final_idx;
                            o_cmd.bytes  = w_hdr_bytes;
                            o_cmd.last   = w_no_payload;
                            n_expected   = w_no_payload ? '0 : w_len;
                            if (w_no_payload) n_taken = 17'd1;
                        end
                    end
                end
            end
            PH_PAYLOAD: begin
                if (w_acc) begin
                    o_push         = 1'b1;
                    o_cmd.bytes[0] = w_b;
                    o_cmd.last     = w_pay_last;
                    n_taken        = w_pay_last ? 17'd1 : w_taken_inc;
                    if (w_pay_last) n_expected = '0;
                end
            end
            default: begin
                n_taken    = 17'd1;
                n_expected = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_INDICATOR;
            r_type     <= TYPE_EVENT;
            r_taken    <= 17'd1;
            r_expected <= '0;
        end else begin
            r_phase    <= n_phase;
            r_type     <= n_type;
            r_taken    <= n_taken;
            r_expected <= n_expected;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc && r_phase == PH_HEADER) begin
            r_hs[w_hidx] <= w_b;
        end
    end

endmodule

>>> hw/rtl/hcipr_queue.sv
// Four-entry command queue between front and back end.
// Depends on hcipr_pkg.
module hcipr_queue import hcipr_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_cmd      i_cmd,
    input  logic      i_pop,
    output t_cmd      o_head,
    output t_q_status o_stat
);

    t_cmd              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wp, r_rp;
    logic [QPTR_W:0]   r_cnt;
    logic              w_do_push, w_do_pop;

    assign o_stat.full  = r_cnt == (QPTR_W + 1)'(QUEUE_DEPTH);
    assign o_stat.empty = r_cnt == '0;
    assign w_do_push    = i_push && !o_stat.full;
    assign w_do_pop     = i_pop && !o_stat.empty;
    assign o_head       = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_do_push) r_wp <= r_wp + 1'b1;
            if (w_do_pop) r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (QPTR_W + 1)'(w_do_push) - (QPTR_W + 1)'(w_do_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_do_push) r_mem[r_wp] <= i_cmd;
    end

endmodule

>>> hw/rtl/hcipr_back.sv
// Back end: expands queued commands into result words, one per cycle
// while not stalled, into the output register. Depends on hcipr_pkg.
module hcipr_back import hcipr_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cmd      i_head,
    input  t_q_status i_qstat,
    output logic      o_pop,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_word o_data
);

    logic      r_valid;
    t_out_word r_data;
    logic [1:0] r_idx;
    logic      w_free;
    logic      w_take;
    logic      w_final;
    t_out_word w_item;

    assign w_free  = !r_valid || !i_stall;
    assign w_take  = w_free && !i_qstat.empty;
    assign w_final = r_idx == i_head.cnt_m1;
    assign o_pop   = w_take && w_final;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_comb begin
        w_item.result_kind = i_head.kind;
        w_item.pkt_type    = i_head.ptype;
        w_item.out_byte    = i_head.bytes[r_idx];
        w_item.packet_last = w_final && i_head.last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else if (w_free) begin
            r_valid <= !i_qstat.empty;
            if (w_take) r_idx <= w_final ? 2'd0 : r_idx + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) r_data <= w_item;
    end

endmodule

>>> hw/rtl/hci_uart_packet_reassembler.sv
// Top level of the H4 packet reassembler: config registers, front end,
// command queue and back end. Depends on hcipr_pkg and the hcipr_* modules.
//
//  channel  direction  handshake                 payload
//  in       input      i_in_valid / o_in_stall   i_in_data  (t_in_word)
//  out      output     o_out_valid / i_out_stall o_out_data (t_out_word)
//  cfg      input      i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// One input word per cycle while the queue is not full; a payload word is written into the
// queue, then into the output register.
// A completed header gives 2 to 4 words, one error word if too long; the back end drains
// one a cycle while unstalled, so the four-entry queue sets when the input stalls.
// Synchronous active-low reset; config registers return to their maxima.
// Input stalls only while the queue is full; output stall backs up the queue.
module hci_uart_packet_reassembler import hcipr_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  t_in_word         i_in_data,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output t_out_word        o_out_data,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [1:0]       i_cfg_index,
    input  logic [LEN_W-1:0] i_cfg_data
);

    t_cfg      r_cfg;
    t_q_status w_qstat;
    t_cmd      w_cmd, w_head;
    logic      w_push, w_pop;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = w_qstat.full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.event_max <= EVENT_MAX_RST;
            r_cfg.acl_max   <= ACL_MAX_RST;
            r_cfg.sco_max   <= SCO_MAX_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_EVENT_MAX: r_cfg.event_max <= i_cfg_data[8:0];
                REG_ACL_MAX:   r_cfg.acl_max   <= i_cfg_data;
                REG_SCO_MAX:   r_cfg.sco_max   <= i_cfg_data[8:0];
                default:       ;
            endcase
        end
    end

    hcipr_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .i_data  (i_in_data),
        .i_cfg   (r_cfg),
        .i_qstat (w_qstat),
        .o_push  (w_push),
        .o_cmd   (w_cmd)
    );

    hcipr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_cmd),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_stat  (w_qstat)
    );

    hcipr_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (w_head),
        .i_qstat (w_qstat),
        .o_pop   (w_pop),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_data  (o_out_data)
    );

`ifndef NO_ASSERTIONS
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_push && w_qstat.full))
        else $error("command pushed into full queue");

    a_error_word_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.result_kind != KIND_BYTE) |->
        (!o_out_data.packet_last && o_out_data.out_byte == 8'd0))
        else $error("error word carries byte or last flag");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_qstat.empty)
        else $error("pop from empty queue");
`endif

endmodule

>>> sim/hci_uart_packet_reassembler_test.sv
// Testbench for the H4 packet reassembler: random and directed UART words,
// an internal reassembly predictor, and a word-by-word check of the output.
// Depends on hcipr_pkg and hci_uart_packet_reassembler.
module hci_uart_packet_reassembler_test;
    import hcipr_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] TYPE_NONE = 2'd3;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_in_valid = 1'b0;
    logic             o_in_stall;
    t_in_word         i_in_data = '0;
    logic             o_out_valid;
    logic             i_out_stall = 1'b0;
    t_out_word        o_out_data;
    logic             i_cfg_valid = 1'b0;
    logic             o_cfg_ready;
    logic [1:0]       i_cfg_index = REG_EVENT_MAX;
    logic [LEN_W-1:0] i_cfg_data = '0;

    t_in_word  uart_rx[$];
    t_out_word due_words[$];
    t_out_word want;
    bit        word_taken = 1'b0;
    bit        failed = 1'b0;
    int        send_gap_pct = 0;
    int        stall_pct = 0;

    // predictor state and register copies
    logic [1:0]       cur_type;
    logic [LEN_W-1:0] taken;
    logic [LEN_W-1:0] pkt_len;
    logic [7:0]       hdr [0:3];
    bit               dropping;
    logic [8:0]       ev_max;
    logic [LEN_W-1:0] acl_max;
    logic [8:0]       sco_max;

    hci_uart_packet_reassembler DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #6 i_clk = ~i_clk;

    function automatic void restart_packet();
        cur_type = TYPE_NONE;
        taken    = 1;
        pkt_len  = 0;
    endfunction

    function automatic void reassemble_byte(input t_in_word w);
        logic [LEN_W-1:0] hlen;
        logic [LEN_W-1:0] plen;
        logic [LEN_W-1:0] lim;
        t_out_word        res;
        int               i;
        if (dropping) begin
            if (w.chunk_last) begin
                dropping = 1'b0;
            end
            return;
        end
        if (cur_type == TYPE_NONE) begin
            taken   = 1;
            pkt_len = 0;
            case (w.data_byte)
                IND_EVENT: cur_type = TYPE_EVENT;
                IND_ACL:   cur_type = TYPE_ACL;
                IND_SCO:   cur_type = TYPE_SCO;
                default: begin
                    res.result_kind = KIND_UNKNOWN;
                    res.pkt_type    = TYPE_EVENT;
                    res.out_byte    = 8'd0;
                    res.packet_last = 1'b0;
                    due_words.insert(due_words.size(), res);
                    dropping = !w.chunk_last;
                end
            endcase
            return;
        end
        res.pkt_type = cur_type;
        if (pkt_len == 0) begin
            case (cur_type)
                TYPE_EVENT: begin
                    hlen = 3;
                    lim  = ev_max;
                end
                TYPE_ACL: begin
                    hlen = 5;
                    lim  = acl_max;
                end
                default: begin
                    hlen = 4;
                    lim  = sco_max;
                end
            endcase
            hdr[taken[1:0] - 2'd1] = w.data_byte;
            taken = taken + 1;
            if (taken < hlen) begin
                return;
            end
            case (cur_type)
                TYPE_EVENT: plen = hdr[1] + 3;
                TYPE_ACL:   plen = {hdr[3], hdr[2]} + 5;
                default:    plen = hdr[2] + 4;
            endcase
            if (plen > lim) begin
                res.result_kind = KIND_TOO_LONG;
                res.out_byte    = 8'd0;
                res.packet_last = 1'b0;
                due_words.insert(due_words.size(), res);
                restart_packet();
                dropping = !w.chunk_last;
                return;
            end
            pkt_len = plen;
            for (i = 0; i + 1 < hlen; i++) begin
                res.result_kind = KIND_BYTE;
                res.out_byte    = hdr[i];
                res.packet_last = (i + 2 == hlen) && (plen == hlen);
                due_words.insert(due_words.size(), res);
            end
            if (plen == hlen) begin
                restart_packet();
            end
            return;
        end
        taken = taken + 1;
        res.result_kind = KIND_BYTE;
        res.out_byte    = w.data_byte;
        res.packet_last = (taken >= pkt_len);
        due_words.insert(due_words.size(), res);
        if (taken >= pkt_len) begin
            restart_packet();
        end
    endfunction

    task automatic queue_byte(input logic [7:0] b, input bit cl);
        t_in_word w;
        w.data_byte  = b;
        w.chunk_last = cl;
        uart_rx.insert(uart_rx.size(), w);
    endtask

    // error word: either it closes the chunk, or some junk follows up to chunk end
    task automatic queue_error_tail(input logic [7:0] b);
        bit cl;
        cl = $urandom_range(0, 1);
        queue_byte(b, cl);
        if (!cl) begin
            repeat ($urandom_range(0, 3)) queue_byte(8'($urandom), 1'b0);
            queue_byte(8'($urandom), 1'b1);
        end
    endtask

    task automatic queue_packet();
        logic [7:0] hb [0:4];
        logic [7:0] b;
        int         hlen, plen, lim, total, cut_at, i;
        bit         too_long, cl;
        if ($urandom_range(0, 99) < 8) begin
            do begin
                b = 8'($urandom);
            end while (b == IND_EVENT || b == IND_ACL || b == IND_SCO);
            queue_error_tail(b);
            return;
        end
        plen  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 60) : $urandom_range(0, 8);
        hb[1] = 8'($urandom);
        hb[2] = 8'($urandom);
        case ($urandom_range(0, 2))
            0: begin
                hlen  = 3;
                lim   = ev_max;
                hb[0] = IND_EVENT;
                hb[2] = 8'(plen);
            end
            1: begin
                hlen  = 5;
                lim   = acl_max;
                hb[0] = IND_ACL;
                if (acl_max < 261 && $urandom_range(0, 3) == 0) begin
                    plen = $urandom_range(256, 65535);
                end
                hb[3] = 8'(plen);
                hb[4] = 8'(plen >> 8);
            end
            default: begin
                hlen  = 4;
                lim   = sco_max;
                hb[0] = IND_SCO;
                hb[3] = 8'(plen);
            end
        endcase
        too_long = (plen + hlen > lim);
        total    = too_long ? hlen : hlen + plen;
        // occasionally break the packet off early
        cut_at   = ($urandom_range(0, 19) == 0) ? $urandom_range(1, total - 1) : total;
        for (i = 0; i < cut_at; i++) begin
            b = (i < hlen) ? hb[i] : 8'($urandom);
            if (too_long && i == hlen - 1) begin
                queue_error_tail(b);
                return;
            end
            cl = ($urandom_range(0, 4) == 0) || (i == total - 1 && $urandom_range(0, 1) == 0);
            queue_byte(b, cl);
        end
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [LEN_W-1:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            REG_EVENT_MAX: ev_max = val[8:0];
            REG_ACL_MAX:   acl_max = val;
            REG_SCO_MAX:   sco_max = val[8:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_limits(input int ev, input int acl, input int sco);
        write_reg(REG_EVENT_MAX, LEN_W'(ev));
        write_reg(REG_ACL_MAX, LEN_W'(acl));
        write_reg(REG_SCO_MAX, LEN_W'(sco));
    endtask

    task automatic wait_drained();
        while (uart_rx.size() != 0 || i_in_valid || due_words.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic queue_random(input int n);
        while (uart_rx.size() < n) queue_packet();
    endtask

    // driver: new word only once the previous one is taken
    always @(negedge i_clk) begin
        if (i_rst_n && (!i_in_valid || word_taken)) begin
            word_taken = 1'b0;
            if (uart_rx.size() > 0 && $urandom_range(0, 99) >= send_gap_pct) begin
                i_in_valid <= 1'b1;
                i_in_data  <= uart_rx.pop_front();
            end else begin
                i_in_valid <= 1'b0;
            end
        end
        i_out_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    // monitor
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            reassemble_byte(i_in_data);
            word_taken = 1'b1;
        end
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (due_words.size() == 0) begin
                $error("output word with none expected: %h", o_out_data);
                failed = 1'b1;
            end else begin
                want = due_words.pop_front();
                if (o_out_data.result_kind !== want.result_kind) begin
                    $error("result_kind: expected %0d, got %0d",
                           want.result_kind, o_out_data.result_kind);
                    failed = 1'b1;
                end
                if (o_out_data.pkt_type !== want.pkt_type) begin
                    $error("pkt_type: expected %0d, got %0d",
                           want.pkt_type, o_out_data.pkt_type);
                    failed = 1'b1;
                end
                if (o_out_data.out_byte !== want.out_byte) begin
                    $error("out_byte: expected %02h, got %02h",
                           want.out_byte, o_out_data.out_byte);
                    failed = 1'b1;
                end
                if (o_out_data.packet_last !== want.packet_last) begin
                    $error("packet_last: expected %0d, got %0d",
                           want.packet_last, o_out_data.packet_last);
                    failed = 1'b1;
                end
            end
        end
    end

    initial begin
        int i;
        restart_packet();
        dropping = 1'b0;
        for (i = 0; i < 4; i++) hdr[i] = 8'd0;
        ev_max  = EVENT_MAX_RST;
        acl_max = ACL_MAX_RST;
        sco_max = SCO_MAX_RST;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset limits, no idling: zero and short payloads, bad indicators
        queue_byte(IND_EVENT, 0); queue_byte(8'h0E, 0); queue_byte(8'h00, 1);
        queue_byte(IND_ACL, 0); queue_byte(8'hFF, 0); queue_byte(8'h0F, 1);
        queue_byte(8'h01, 0); queue_byte(8'h00, 0); queue_byte(8'hFF, 1);
        queue_byte(IND_SCO, 1); queue_byte(8'h01, 0); queue_byte(8'h20, 0);
        queue_byte(8'h01, 0); queue_byte(8'hAA, 1);
        queue_byte(IND_ACL, 0); queue_byte(8'h00, 0); queue_byte(8'h00, 0);
        queue_byte(8'h00, 0); queue_byte(8'h00, 1);
        queue_byte(IND_SCO, 0); queue_byte(8'h00, 0); queue_byte(8'h00, 0);
        queue_byte(8'h00, 0);
        queue_byte(8'hFF, 0); queue_byte(8'h80, 1);
        queue_byte(8'h00, 1);
        wait_drained();

        // event limit below header length
        set_limits(1, 65540, 259);
        queue_byte(IND_EVENT, 0); queue_byte(8'h0E, 0); queue_byte(8'h00, 0);
        queue_byte(8'h11, 0); queue_byte(8'h22, 1);
        queue_byte(IND_EVENT, 0); queue_byte(8'h00, 0); queue_byte(8'h05, 1);
        queue_random(40);
        wait_drained();

        set_limits(258, 5, 4);
        send_gap_pct = 52;
        queue_byte(IND_ACL, 0); queue_byte(8'h12, 0); queue_byte(8'h34, 0);
        queue_byte(8'hFF, 0); queue_byte(8'hFF, 1);
        queue_random(40);
        wait_drained();

        set_limits($urandom_range(3, 40), $urandom_range(5, 40), $urandom_range(4, 40));
        send_gap_pct = 0;
        stall_pct    = 52;
        queue_random(40);
        wait_drained();

        // event packet exactly at the event limit
        set_limits(35, 1, 1);
        send_gap_pct = 24;
        stall_pct    = 24;
        queue_byte(IND_EVENT, 0); queue_byte(8'h3E, 0); queue_byte(8'h20, 0);
        for (i = 0; i < 32; i++) queue_byte(8'($urandom), i == 31);
        queue_random(60);
        wait_drained();

        if (!failed) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
